/* rtl/zlhw_pkg.sv */
// Shared types and constants for the ZIP local header walker.
`timescale 1ns / 1ps

package zlhw_pkg;

	// Local file header signature, little-endian on the wire.
	localparam logic [31:0] LOCAL_SIG     = 32'h04034b50;
	// Signature plus fixed header body.
	localparam logic [31:0] FIXED_HEADER  = 32'd30;
	// Length of an optional data descriptor.
	localparam logic [31:0] DESC_BYTES    = 32'd12;
	// Flag bit that announces a data descriptor.
	localparam int          DESC_FLAG_BIT = 3;
	// Index of the last signature byte.
	localparam logic [31:0] SIG_LAST      = 32'd3;

	// Byte offsets inside the 26-byte header body.
	localparam logic [4:0] HB_FLAG_LO   = 5'd2;
	localparam logic [4:0] HB_FLAG_HI   = 5'd3;
	localparam logic [4:0] HB_METHOD_LO = 5'd4;
	localparam logic [4:0] HB_METHOD_HI = 5'd5;
	localparam logic [4:0] HB_COMP_0    = 5'd14;
	localparam logic [4:0] HB_COMP_1    = 5'd15;
	localparam logic [4:0] HB_COMP_2    = 5'd16;
	localparam logic [4:0] HB_COMP_3    = 5'd17;
	localparam logic [4:0] HB_UNCOMP_0  = 5'd18;
	localparam logic [4:0] HB_UNCOMP_1  = 5'd19;
	localparam logic [4:0] HB_UNCOMP_2  = 5'd20;
	localparam logic [4:0] HB_UNCOMP_3  = 5'd21;
	localparam logic [4:0] HB_NAME_LO   = 5'd22;
	localparam logic [4:0] HB_NAME_HI   = 5'd23;
	localparam logic [4:0] HB_EXTRA_LO  = 5'd24;
	localparam logic [4:0] HB_EXTRA_HI  = 5'd25;

	// Positions in the per-byte result mask, in delivery order.
	localparam int M_NAME  = 0;
	localparam int M_ENTRY = 1;
	localparam int M_END   = 2;
	localparam int M_TRUNC = 3;

	typedef enum logic [2:0] {
		PH_SIG,
		PH_HDR,
		PH_NAME,
		PH_EXTRA,
		PH_DATA,
		PH_DESC,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NAME,
		KIND_ENTRY,
		KIND_END,
		KIND_TRUNC
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} byte_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_char;
		logic [15:0] method;
		logic [15:0] flag_bits;
		logic [31:0] compressed_size;
		logic [31:0] uncompressed_size;
		logic [31:0] data_offset;
		logic [15:0] name_length;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [15:0] method;
		logic [15:0] flag_bits;
		logic [31:0] compressed_size;
		logic [31:0] uncompressed_size;
		logic [31:0] data_offset;
		logic [15:0] name_length;
	} entry_t;

	// All results that one input byte causes.
	typedef struct packed {
		logic [3:0] mask;
		logic [7:0] name_char;
		entry_t     entry;
	} bundle_t;

endpackage

/* rtl/zlhw_parser.sv */
// Header walking state and per-byte result decode.
`timescale 1ns / 1ps

module zlhw_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  zlhw_pkg::byte_t   in_byte,
	output zlhw_pkg::bundle_t bundle,
	output zlhw_pkg::phase_t  phase
);

	zlhw_pkg::phase_t phase_q, phase_n;
	logic [31:0] cnt_q, cnt_n;
	logic [31:0] sig_q, sig_n;
	logic [31:0] pos_q, pos_n;
	logic [15:0] flag_q, flag_n;
	logic [15:0] method_q, method_n;
	logic [31:0] comp_q, comp_n;
	logic [31:0] uncomp_q, uncomp_n;
	logic [15:0] name_len_q, name_len_n;
	logic [15:0] extra_q, extra_n;
	logic [31:0] base_q, base_n;
	logic [31:0] tail_q, tail_n;
	logic [31:0] off_q, off_n;

	logic [7:0]  b;
	logic [4:0]  hdr_idx;
	logic [31:0] cnt_inc;
	logic [31:0] off_hdr;
	logic [31:0] off_sel;
	logic [15:0] x_len;
	logic [3:0]  mask;
	logic        enter_x;
	logic        enter_d;
	logic        enter_s;
	logic        fin;

	assign b       = in_byte.data_byte;
	assign hdr_idx = cnt_q[4:0];
	assign cnt_inc = cnt_q + 32'd1;
	// Data offset when the last header byte is the extra length high byte.
	assign off_hdr = base_q + {16'b0, b, extra_q[7:0]};
	assign off_sel = (phase_q == zlhw_pkg::PH_HDR) ? off_hdr : off_q;
	assign phase   = phase_q;

	// Entry record fields as they stand when the record goes out.
	assign bundle.mask                    = mask;
	assign bundle.name_char               = b;
	assign bundle.entry.method            = method_q;
	assign bundle.entry.flag_bits         = flag_q;
	assign bundle.entry.compressed_size   = comp_q;
	assign bundle.entry.uncompressed_size = uncomp_q;
	assign bundle.entry.data_offset       = off_sel;
	assign bundle.entry.name_length       = name_len_q;

	// Next state and result mask for the byte on the input.
	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		sig_n      = sig_q;
		pos_n      = pos_q;
		flag_n     = flag_q;
		method_n   = method_q;
		comp_n     = comp_q;
		uncomp_n   = uncomp_q;
		name_len_n = name_len_q;
		extra_n    = extra_q;
		base_n     = base_q;
		tail_n     = tail_q;
		off_n      = off_q;
		mask       = 4'b0000;
		x_len      = extra_q;
		enter_x    = 1'b0;
		enter_d    = 1'b0;
		enter_s    = 1'b0;
		fin        = 1'b0;

		case (phase_q)
			zlhw_pkg::PH_SIG: begin
				sig_n = {b, sig_q[31:8]};
				cnt_n = cnt_inc;
				if (cnt_q == zlhw_pkg::SIG_LAST) begin
					cnt_n = '0;
					if (sig_n == zlhw_pkg::LOCAL_SIG) begin
						phase_n = zlhw_pkg::PH_HDR;
					end else begin
						mask[zlhw_pkg::M_END] = 1'b1;
						phase_n = zlhw_pkg::PH_DONE;
					end
				end
			end
			zlhw_pkg::PH_HDR: begin
				cnt_n = cnt_inc;
				case (hdr_idx)
					zlhw_pkg::HB_FLAG_LO:   flag_n[7:0]      = b;
					zlhw_pkg::HB_FLAG_HI:   flag_n[15:8]     = b;
					zlhw_pkg::HB_METHOD_LO: method_n[7:0]    = b;
					zlhw_pkg::HB_METHOD_HI: method_n[15:8]   = b;
					zlhw_pkg::HB_COMP_0:    comp_n[7:0]      = b;
					zlhw_pkg::HB_COMP_1:    comp_n[15:8]     = b;
					zlhw_pkg::HB_COMP_2:    comp_n[23:16]    = b;
					zlhw_pkg::HB_COMP_3:    comp_n[31:24]    = b;
					zlhw_pkg::HB_UNCOMP_0:  uncomp_n[7:0]    = b;
					zlhw_pkg::HB_UNCOMP_1:  uncomp_n[15:8]   = b;
					zlhw_pkg::HB_UNCOMP_2:  uncomp_n[23:16]  = b;
					zlhw_pkg::HB_UNCOMP_3:  uncomp_n[31:24]  = b;
					zlhw_pkg::HB_NAME_LO:   name_len_n[7:0]  = b;
					zlhw_pkg::HB_NAME_HI:   name_len_n[15:8] = b;
					zlhw_pkg::HB_EXTRA_LO:  extra_n[7:0]     = b;
					zlhw_pkg::HB_EXTRA_HI:  extra_n[15:8]    = b;
					default: ;
				endcase
				// Partial sums, taken once their operands are complete.
				if (hdr_idx == zlhw_pkg::HB_UNCOMP_0) begin
					tail_n = comp_q +
						(flag_q[zlhw_pkg::DESC_FLAG_BIT] ? zlhw_pkg::DESC_BYTES : 32'd0);
				end
				if (hdr_idx == zlhw_pkg::HB_EXTRA_LO) begin
					base_n = pos_q + zlhw_pkg::FIXED_HEADER + {16'b0, name_len_q};
				end
				if (hdr_idx == zlhw_pkg::HB_EXTRA_HI) begin
					cnt_n = '0;
					off_n = off_hdr;
					if (name_len_q != 16'd0) begin
						phase_n = zlhw_pkg::PH_NAME;
					end else begin
						mask[zlhw_pkg::M_ENTRY] = 1'b1;
						enter_x = 1'b1;
						x_len   = extra_n;
					end
				end
			end
			zlhw_pkg::PH_NAME: begin
				mask[zlhw_pkg::M_NAME] = 1'b1;
				cnt_n = cnt_inc;
				if (cnt_inc == {16'b0, name_len_q}) begin
					mask[zlhw_pkg::M_ENTRY] = 1'b1;
					enter_x = 1'b1;
				end
			end
			zlhw_pkg::PH_EXTRA: begin
				cnt_n = cnt_inc;
				if (cnt_inc == {16'b0, extra_q}) begin
					enter_d = 1'b1;
				end
			end
			zlhw_pkg::PH_DATA: begin
				cnt_n = cnt_inc;
				if (cnt_inc == comp_q) begin
					enter_s = 1'b1;
				end
			end
			zlhw_pkg::PH_DESC: begin
				cnt_n = cnt_inc;
				if (cnt_inc == zlhw_pkg::DESC_BYTES) begin
					fin = 1'b1;
				end
			end
			default: begin
				phase_n = zlhw_pkg::PH_DONE;
			end
		endcase

		// Pass over empty sections without consuming a byte.
		if (enter_x) begin
			cnt_n = '0;
			if (x_len != 16'd0) begin
				phase_n = zlhw_pkg::PH_EXTRA;
			end else begin
				enter_d = 1'b1;
			end
		end
		if (enter_d) begin
			cnt_n = '0;
			if (comp_q != 32'd0) begin
				phase_n = zlhw_pkg::PH_DATA;
			end else begin
				enter_s = 1'b1;
			end
		end
		if (enter_s) begin
			cnt_n = '0;
			if (flag_q[zlhw_pkg::DESC_FLAG_BIT]) begin
				phase_n = zlhw_pkg::PH_DESC;
			end else begin
				fin = 1'b1;
			end
		end
		if (fin) begin
			pos_n   = off_sel + tail_q;
			phase_n = zlhw_pkg::PH_SIG;
			cnt_n   = '0;
			sig_n   = '0;
		end

		// Input that ends before a terminating signature is truncated.
		if (in_byte.end_of_input && (phase_n != zlhw_pkg::PH_DONE) &&
				(phase_q != zlhw_pkg::PH_DONE)) begin
			mask[zlhw_pkg::M_TRUNC] = 1'b1;
			phase_n = zlhw_pkg::PH_DONE;
		end
	end

	// Walker state registers, updated once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= zlhw_pkg::PH_SIG;
			cnt_q      <= '0;
			sig_q      <= '0;
			pos_q      <= '0;
			flag_q     <= '0;
			method_q   <= '0;
			comp_q     <= '0;
			uncomp_q   <= '0;
			name_len_q <= '0;
			extra_q    <= '0;
			base_q     <= '0;
			tail_q     <= '0;
			off_q      <= '0;
		end else if (take) begin
			phase_q    <= phase_n;
			cnt_q      <= cnt_n;
			sig_q      <= sig_n;
			pos_q      <= pos_n;
			flag_q     <= flag_n;
			method_q   <= method_n;
			comp_q     <= comp_n;
			uncomp_q   <= uncomp_n;
			name_len_q <= name_len_n;
			extra_q    <= extra_n;
			base_q     <= base_n;
			tail_q     <= tail_n;
			off_q      <= off_n;
		end
	end

endmodule

/* rtl/zlhw_emitter.sv */
// Two-slot result buffer that delivers one result per request.
`timescale 1ns / 1ps

module zlhw_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  zlhw_pkg::bundle_t bundle,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output zlhw_pkg::result_t out_data,
	output logic              s1_full
);

	logic [3:0]        s1_mask_q;
	zlhw_pkg::bundle_t s1_q;
	logic [3:0]        cur_mask_q;
	zlhw_pkg::bundle_t cur_q;

	logic [3:0] head;
	logic [3:0] rest;
	logic       out_take;
	logic       cur_free;
	logic       is_entry;

	// Results leave in mask order: name byte, entry, end, truncation.
	always_comb begin
		if (cur_mask_q[zlhw_pkg::M_NAME]) begin
			head = 4'b0001;
		end else if (cur_mask_q[zlhw_pkg::M_ENTRY]) begin
			head = 4'b0010;
		end else if (cur_mask_q[zlhw_pkg::M_END]) begin
			head = 4'b0100;
		end else if (cur_mask_q[zlhw_pkg::M_TRUNC]) begin
			head = 4'b1000;
		end else begin
			head = 4'b0000;
		end
	end

	assign rest      = cur_mask_q & ~head;
	assign out_valid = |cur_mask_q;
	assign out_take  = out_valid && !out_stall;
	assign cur_free  = !out_valid || (out_take && (rest == 4'b0000));
	assign in_stall  = s1_full && !cur_free;
	assign s1_full   = |s1_mask_q;
	assign is_entry  = head[zlhw_pkg::M_ENTRY];

	// Result fields; everything outside the result's kind reads zero.
	always_comb begin
		if (head[zlhw_pkg::M_NAME]) begin
			out_data.kind = zlhw_pkg::KIND_NAME;
		end else if (head[zlhw_pkg::M_ENTRY]) begin
			out_data.kind = zlhw_pkg::KIND_ENTRY;
		end else if (head[zlhw_pkg::M_END]) begin
			out_data.kind = zlhw_pkg::KIND_END;
		end else begin
			out_data.kind = zlhw_pkg::KIND_TRUNC;
		end
		out_data.name_char = head[zlhw_pkg::M_NAME] ? cur_q.name_char : 8'd0;
		out_data.method            = is_entry ? cur_q.entry.method : 16'd0;
		out_data.flag_bits         = is_entry ? cur_q.entry.flag_bits : 16'd0;
		out_data.compressed_size   = is_entry ? cur_q.entry.compressed_size : 32'd0;
		out_data.uncompressed_size = is_entry ? cur_q.entry.uncompressed_size : 32'd0;
		out_data.data_offset       = is_entry ? cur_q.entry.data_offset : 32'd0;
		out_data.name_length       = is_entry ? cur_q.entry.name_length : 16'd0;
		out_data.last_of_run       = (rest == 4'b0000);
	end

	// Occupancy of both slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_mask_q  <= '0;
			cur_mask_q <= '0;
		end else begin
			if (cur_free) begin
				cur_mask_q <= s1_mask_q;
			end else if (out_take) begin
				cur_mask_q <= rest;
			end
			if (load) begin
				s1_mask_q <= bundle.mask;
			end else if (cur_free) begin
				s1_mask_q <= '0;
			end
		end
	end

	// Slot payloads.
	always_ff @(posedge clk) begin
		if (cur_free) begin
			cur_q <= s1_q;
		end
		if (load) begin
			s1_q <= bundle;
		end
	end

endmodule

/* rtl/zip_local_header_walker_unit.sv */
// Top level of the ZIP local header walker.
`timescale 1ns / 1ps

// Takes an archive one byte per request and walks its local file headers.
// Each file name byte comes out as its own result, followed by an entry
// record with method, flags, sizes, name length and the offset of the entry
// data; extra fields, compressed data and 12-byte data descriptors (flag
// bit 3) are skipped. A signature other than a local header ends the walk
// with a clean-end result; input that ends first gives a truncation result.
// After either, further bytes are dropped until reset. A byte is accepted
// every cycle while each byte causes at most one result and result_stall is
// low. The result port moves one result per cycle while result_stall is low,
// so a byte that causes two or three results (last name byte plus entry
// record, plus truncation) can hold the input until they have gone out.
// Results pass through a decode slot and then an output slot.
module zip_local_header_walker_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  zlhw_pkg::byte_t   byte_data,
	output logic              result_valid,
	input  logic              result_stall,
	output zlhw_pkg::result_t result_data
);

	logic              accept;
	logic              load;
	logic              s1_full;
	zlhw_pkg::bundle_t bundle;
	zlhw_pkg::phase_t  phase;

	assign accept = byte_valid && !byte_stall;
	assign load   = accept && (bundle.mask != 4'b0000);

	// Header walk and per-byte decode.
	zlhw_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (accept),
		.in_byte (byte_data),
		.bundle  (bundle),
		.phase   (phase)
	);

	// Result buffering and serialization.
	zlhw_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.in_stall  (byte_stall),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (result_data),
		.s1_full   (s1_full)
	);

	// The input is only held back while the decode slot is occupied.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_full |-> !byte_stall)
		else $error("input stalled with an empty decode slot");

	// A finished walk stays finished.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase == zlhw_pkg::PH_DONE) |=> (phase == zlhw_pkg::PH_DONE))
		else $error("walk resumed after it ended");

	// Terminal results close the run of their byte.
	a_terminal_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.kind == zlhw_pkg::KIND_TRUNC ||
			result_data.kind == zlhw_pkg::KIND_END) |-> result_data.last_of_run)
		else $error("terminal result not last of its run");

	// Data offset, method and name length are zero on every other kind of result.
	a_entry_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.kind != zlhw_pkg::KIND_ENTRY) |->
			(result_data.data_offset == 32'd0) && (result_data.method == 16'd0) &&
			(result_data.name_length == 16'd0))
		else $error("entry fields set on a non-entry result");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the ZIP local header walker unit.
`timescale 1ns / 1ps

module testbench;

	// Bytes in the header body that follows the signature.
	localparam int HEADER_BODY = 26;
	// Bytes of random entries in the main walk.
	localparam int RANDOM_BYTES = 270;
	// Cycles allowed before the run is declared hung.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles to wait after the last expected result for strays.
	localparam int SETTLE_CYCLES = 20;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_HEAVY,
		STALL_EVERY_THIRD
	} stall_mode_t;

	typedef enum int {
		END_BAD_SIG,
		END_BAD_SIG_LAST,
		END_AT_BOUNDARY,
		END_ON_NAME,
		END_IN_HUGE_DATA,
		END_IN_HEADER
	} end_style_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              byte_valid   = 1'b0;
	logic              byte_stall;
	zlhw_pkg::byte_t   byte_data    = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	zlhw_pkg::result_t result_data;

	// Walker state mirrored by the predictor.
	zlhw_pkg::phase_t walk_phase    = zlhw_pkg::PH_SIG;
	logic [31:0]      walk_count    = '0;
	logic [31:0]      sig_shift     = '0;
	logic [31:0]      entry_pos     = '0;
	logic [15:0]      hdr_flags     = '0;
	logic [15:0]      hdr_method    = '0;
	logic [31:0]      hdr_comp      = '0;
	logic [31:0]      hdr_uncomp    = '0;
	logic [15:0]      hdr_name_len  = '0;
	logic [15:0]      hdr_extra_len = '0;
	logic             walk_finished = 1'b0;

	zlhw_pkg::result_t expected_results[$];
	logic [7:0]        archive_bytes[$];
	int                error_count  = 0;
	int                cycle_count  = 0;
	int                burst_left   = 0;
	stall_mode_t       stall_mode   = STALL_NONE;
	int                stall_span   = 0;
	int                stall_streak = 0;

	zip_local_header_walker_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Watchdog: a hung walk ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The result side stalls in modes that change at random intervals.
	always @(posedge clk) begin : stall_pattern
		logic stall_now;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (stall_span == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_span = $urandom_range(16, 128);
			end
			stall_span--;
			case (stall_mode)
				STALL_NONE: stall_now = 1'b0;
				STALL_COIN: stall_now = ($urandom_range(0, 1) == 1);
				STALL_HEAVY: stall_now = (stall_streak < 12) && ($urandom_range(0, 7) != 0);
				default: stall_now = (cycle_count % 3 == 0);
			endcase
			stall_streak = stall_now ? stall_streak + 1 : 0;
			result_stall <= stall_now;
		end
	end

	task automatic report_failure(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			report_failure($sformatf("mismatch in %s: expected 0x%0h, got 0x%0h",
				field, want, got));
		end
	endtask

	// Every accepted result is compared with the oldest expected one.
	always @(posedge clk) begin : result_checker
		zlhw_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_failure($sformatf("unexpected result of kind %0d",
					result_data.kind));
			end else begin
				want = expected_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(result_data.kind));
				check_field("name_char", 32'(want.name_char), 32'(result_data.name_char));
				check_field("method", 32'(want.method), 32'(result_data.method));
				check_field("flag_bits", 32'(want.flag_bits), 32'(result_data.flag_bits));
				check_field("compressed_size", want.compressed_size,
					result_data.compressed_size);
				check_field("uncompressed_size", want.uncompressed_size,
					result_data.uncompressed_size);
				check_field("data_offset", want.data_offset, result_data.data_offset);
				check_field("name_length", 32'(want.name_length),
					32'(result_data.name_length));
				check_field("last_of_run", 32'(want.last_of_run),
					32'(result_data.last_of_run));
			end
		end
	end

	// Builds one result; only an entry record carries the header fields.
	function automatic zlhw_pkg::result_t walk_result(input zlhw_pkg::kind_t kind,
			input logic [7:0] ch);
		zlhw_pkg::result_t r;
		r = '0;
		r.kind = kind;
		r.name_char = ch;
		if (kind == zlhw_pkg::KIND_ENTRY) begin
			r.method = hdr_method;
			r.flag_bits = hdr_flags;
			r.compressed_size = hdr_comp;
			r.uncompressed_size = hdr_uncomp;
			r.data_offset = entry_pos + zlhw_pkg::FIXED_HEADER + 32'(hdr_name_len)
				+ 32'(hdr_extra_len);
			r.name_length = hdr_name_len;
		end
		return r;
	endfunction

	// Moves the position past the whole entry and looks for the next signature.
	function automatic void close_entry();
		entry_pos = entry_pos + zlhw_pkg::FIXED_HEADER + 32'(hdr_name_len)
			+ 32'(hdr_extra_len) + hdr_comp
			+ (hdr_flags[zlhw_pkg::DESC_FLAG_BIT] ? zlhw_pkg::DESC_BYTES : 32'd0);
		walk_phase = zlhw_pkg::PH_SIG;
		walk_count = '0;
		sig_shift = '0;
	endfunction

	// Empty sections are passed over without taking a byte.
	function automatic void open_descriptor();
		walk_count = '0;
		if (hdr_flags[zlhw_pkg::DESC_FLAG_BIT]) begin
			walk_phase = zlhw_pkg::PH_DESC;
		end else begin
			close_entry();
		end
	endfunction

	function automatic void open_data();
		walk_count = '0;
		if (hdr_comp != 0) begin
			walk_phase = zlhw_pkg::PH_DATA;
		end else begin
			open_descriptor();
		end
	endfunction

	function automatic void open_extra();
		walk_count = '0;
		if (hdr_extra_len != 0) begin
			walk_phase = zlhw_pkg::PH_EXTRA;
		end else begin
			open_data();
		end
	endfunction

	// Advances the mirrored walk by one byte and queues the results it causes.
	task automatic walk_byte(input logic [7:0] b, input logic eoi);
		zlhw_pkg::result_t caused[$];
		if (!walk_finished) begin
			case (walk_phase)
				zlhw_pkg::PH_SIG: begin
					sig_shift = {b, sig_shift[31:8]};
					walk_count++;
					if (walk_count > zlhw_pkg::SIG_LAST) begin
						walk_count = '0;
						if (sig_shift == zlhw_pkg::LOCAL_SIG) begin
							walk_phase = zlhw_pkg::PH_HDR;
						end else begin
							caused.push_back(walk_result(zlhw_pkg::KIND_END, 8'h00));
							walk_phase = zlhw_pkg::PH_DONE;
							walk_finished = 1'b1;
						end
					end
				end
				zlhw_pkg::PH_HDR: begin
					case (walk_count[4:0])
						zlhw_pkg::HB_FLAG_LO: hdr_flags[7:0] = b;
						zlhw_pkg::HB_FLAG_HI: hdr_flags[15:8] = b;
						zlhw_pkg::HB_METHOD_LO: hdr_method[7:0] = b;
						zlhw_pkg::HB_METHOD_HI: hdr_method[15:8] = b;
						zlhw_pkg::HB_COMP_0: hdr_comp[7:0] = b;
						zlhw_pkg::HB_COMP_1: hdr_comp[15:8] = b;
						zlhw_pkg::HB_COMP_2: hdr_comp[23:16] = b;
						zlhw_pkg::HB_COMP_3: hdr_comp[31:24] = b;
						zlhw_pkg::HB_UNCOMP_0: hdr_uncomp[7:0] = b;
						zlhw_pkg::HB_UNCOMP_1: hdr_uncomp[15:8] = b;
						zlhw_pkg::HB_UNCOMP_2: hdr_uncomp[23:16] = b;
						zlhw_pkg::HB_UNCOMP_3: hdr_uncomp[31:24] = b;
						zlhw_pkg::HB_NAME_LO: hdr_name_len[7:0] = b;
						zlhw_pkg::HB_NAME_HI: hdr_name_len[15:8] = b;
						zlhw_pkg::HB_EXTRA_LO: hdr_extra_len[7:0] = b;
						zlhw_pkg::HB_EXTRA_HI: hdr_extra_len[15:8] = b;
						default: ;
					endcase
					walk_count++;
					if (walk_count >= HEADER_BODY) begin
						walk_count = '0;
						if (hdr_name_len != 0) begin
							walk_phase = zlhw_pkg::PH_NAME;
						end else begin
							caused.push_back(walk_result(zlhw_pkg::KIND_ENTRY, 8'h00));
							open_extra();
						end
					end
				end
				zlhw_pkg::PH_NAME: begin
					caused.push_back(walk_result(zlhw_pkg::KIND_NAME, b));
					walk_count++;
					if (walk_count >= hdr_name_len) begin
						caused.push_back(walk_result(zlhw_pkg::KIND_ENTRY, 8'h00));
						open_extra();
					end
				end
				zlhw_pkg::PH_EXTRA: begin
					walk_count++;
					if (walk_count >= hdr_extra_len) begin
						open_data();
					end
				end
				zlhw_pkg::PH_DATA: begin
					walk_count++;
					if (walk_count >= hdr_comp) begin
						open_descriptor();
					end
				end
				zlhw_pkg::PH_DESC: begin
					walk_count++;
					if (walk_count >= zlhw_pkg::DESC_BYTES) begin
						close_entry();
					end
				end
				default: begin
					walk_phase = zlhw_pkg::PH_DONE;
					walk_finished = 1'b1;
				end
			endcase
			// Input that stops before a clean end is reported after the rest.
			if (eoi && !walk_finished) begin
				caused.push_back(walk_result(zlhw_pkg::KIND_TRUNC, 8'h00));
				walk_phase = zlhw_pkg::PH_DONE;
				walk_finished = 1'b1;
			end
			if (caused.size() > 0) begin
				caused[caused.size() - 1].last_of_run = 1'b1;
			end
			foreach (caused[i]) begin
				expected_results.push_back(caused[i]);
			end
		end
	endtask

	// Sends one byte as a request, in bursts with random gaps between them.
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		zlhw_pkg::byte_t req;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req.data_byte = b;
		req.end_of_input = eoi;
		byte_data <= req;
		byte_valid <= 1'b1;
		do @(posedge clk); while (byte_stall);
		walk_byte(b, eoi);
	endtask

	// Holds the sender back until every expected result has come out.
	task automatic drain_results();
		byte_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Sends the built archive bytes; the byte at index cut ends the input.
	task automatic send_archive(input int cut);
		foreach (archive_bytes[i]) begin
			send_byte(archive_bytes[i], i == cut);
			if (i == cut) begin
				break;
			end
		end
	endtask

	task automatic push_le(input logic [31:0] value, input int count);
		for (int k = 0; k < count; k++) begin
			archive_bytes.push_back(value[8 * k +: 8]);
		end
	endtask

	task automatic push_random(input int count);
		repeat (count) archive_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Signature, header body, name and extra field of one entry.
	task automatic append_header(input logic [15:0] method, input logic [15:0] flags,
			input logic [31:0] comp, input logic [31:0] uncomp,
			input logic [15:0] name_len, input logic [15:0] extra_len);
		push_le(zlhw_pkg::LOCAL_SIG, 4);
		push_random(2);
		push_le(32'(flags), 2);
		push_le(32'(method), 2);
		push_random(8);
		push_le(comp, 4);
		push_le(uncomp, 4);
		push_le(32'(name_len), 2);
		push_le(32'(extra_len), 2);
		push_random(int'(name_len) + int'(extra_len));
	endtask

	task automatic append_entry(input logic [15:0] method, input logic [15:0] flags,
			input logic [31:0] comp, input logic [31:0] uncomp,
			input logic [15:0] name_len, input logic [15:0] extra_len);
		append_header(method, flags, comp, uncomp, name_len, extra_len);
		push_random(int'(comp));
		if (flags[zlhw_pkg::DESC_FLAG_BIT]) begin
			push_random(int'(zlhw_pkg::DESC_BYTES));
		end
	endtask

	// Short sections keep the walk fast while every phase is visited.
	task automatic append_random_entry();
		logic [31:0] comp;
		int name_len;
		int extra_len;
		name_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
		extra_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		comp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
		append_entry(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), comp,
			$urandom, 16'(name_len), 16'(extra_len));
	endtask

	// Entries whose name, extra and data are empty; only the second has a descriptor.
	task automatic test_empty_sections();
		archive_bytes.delete();
		append_entry(16'h0000, 16'h0000, 32'd0, 32'h0000_0000, 16'd0, 16'd0);
		// All flag bits set: the descriptor follows the header directly.
		append_entry(16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0);
		send_archive(-1);
	endtask

	// Name bytes at both extremes, plus short extra, data and descriptor.
	task automatic test_extreme_fields();
		int start;
		archive_bytes.delete();
		start = archive_bytes.size();
		append_entry(16'h0000, 16'hFFF7, 32'd3, 32'h0000_0000, 16'd2, 16'd1);
		archive_bytes[start + zlhw_pkg::FIXED_HEADER] = 8'h00;
		archive_bytes[start + zlhw_pkg::FIXED_HEADER + 1] = 8'hFF;
		append_entry(16'h0008, 16'h0008, 32'd1, 32'h8000_0001, 16'd1, 16'd0);
		send_archive(-1);
	endtask

	// Well-formed entries with random content, with one full drain halfway.
	task automatic test_random_archive();
		int sent;
		bit drained;
		sent = 0;
		drained = 1'b0;
		while (sent < RANDOM_BYTES) begin
			archive_bytes.delete();
			append_random_entry();
			send_archive(-1);
			sent += archive_bytes.size();
			if (!drained && sent >= RANDOM_BYTES / 2) begin
				drain_results();
				drained = 1'b1;
			end
		end
	endtask

	// The walk can end only once per reset, so one ending is picked at random.
	task automatic test_walk_end();
		end_style_t style;
		logic [31:0] bad_word;
		int cut;
		archive_bytes.delete();
		style = end_style_t'($urandom_range(0, 5));
		if ($urandom_range(0, 1)) begin
			bad_word = zlhw_pkg::LOCAL_SIG ^ (32'd1 << $urandom_range(0, 31));
		end else begin
			bad_word = $urandom;
			if (bad_word == zlhw_pkg::LOCAL_SIG) begin
				bad_word = ~bad_word;
			end
		end
		cut = -1;
		case (style)
			END_BAD_SIG: begin
				push_le(bad_word, 4);
			end
			END_BAD_SIG_LAST: begin
				// A clean end wins over the end of input on the same byte.
				push_le(bad_word, 4);
				cut = archive_bytes.size() - 1;
			end
			END_AT_BOUNDARY: begin
				append_random_entry();
				cut = archive_bytes.size() - 1;
			end
			END_ON_NAME: begin
				// Last name byte, entry record and truncation from one byte.
				append_entry(16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)) & 16'hFFF7,
					32'd0, $urandom, 16'($urandom_range(1, 4)), 16'd0);
				cut = archive_bytes.size() - 1;
			end
			END_IN_HUGE_DATA: begin
				append_header(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
				push_random($urandom_range(1, 8));
				cut = archive_bytes.size() - 1;
			end
			default: begin
				append_random_entry();
				cut = $urandom_range(0, zlhw_pkg::FIXED_HEADER - 1);
			end
		endcase
		send_archive(cut);
	endtask

	// Once the walk has ended, further bytes cause nothing.
	task automatic test_after_finish();
		repeat (6) send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 1) == 1));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_sections();
		test_extreme_fields();
		drain_results();
		test_random_archive();
		test_walk_end();
		test_after_finish();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
